// ===== rtl/uhts_pkg.sv =====
// Shared types, codes and constants of the USB host transfer sequencer.
package uhts_pkg;

    // Default size of the transfer buffer in bytes.
    localparam int BUFFER_BYTES_DEF = 64;

    // Token and handshake PIDs.
    localparam logic [3:0] PID_OUT   = 4'h1;
    localparam logic [3:0] PID_ACK   = 4'h2;
    localparam logic [3:0] PID_IN    = 4'h9;
    localparam logic [3:0] PID_NAK   = 4'hA;
    localparam logic [3:0] PID_SETUP = 4'hD;
    localparam logic [3:0] PID_STALL = 4'hE;
    localparam logic [3:0] PID_NONE  = 4'h0;

    // Size of a SETUP data packet and the NAK limit that means no limit.
    localparam logic [6:0] SETUP_BYTES = 7'h08;
    localparam logic [7:0] NAK_UNLIMITED = 8'hFF;

    // Configuration register indexes.
    localparam logic CFG_IN_NAK_LIMIT  = 1'b0;
    localparam logic CFG_OUT_NAK_LIMIT = 1'b1;

    // Kinds of input transaction.
    typedef enum logic [1:0] {
        KIND_CONTROL = 2'd0,
        KIND_IN      = 2'd1,
        KIND_OUT     = 2'd2,
        KIND_RESULT  = 2'd3
    } t_kind;

    // Stages of a transfer.
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_SETUP      = 3'd1,
        ST_CTL_IN     = 3'd2,
        ST_CTL_OUT    = 3'd3,
        ST_STATUS_IN  = 3'd4,
        ST_STATUS_OUT = 3'd5,
        ST_BULK_IN    = 3'd6,
        ST_BULK_OUT   = 3'd7
    } t_stage;

    // One input transaction.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  endpoint;
        logic [6:0]  max_packet;
        logic [15:0] transfer_length;
        logic        direction_in;
        logic        has_buffer;
        logic        saved_rx_toggle;
        logic        saved_tx_toggle;
        logic        completed;
        logic [3:0]  response_pid;
        logic [6:0]  received_length;
        logic        toggle_ok;
    } t_item;

    // Transfer state kept between transactions.
    typedef struct packed {
        t_stage      stage;
        logic [15:0] remaining;
        logic [7:0]  retry_count;
        logic [3:0]  endpoint;
        logic [6:0]  packet_limit;
        logic        rx_toggle;
        logic        tx_toggle;
        logic        ctl_dir;
        logic        keep_rx;
        logic        keep_tx;
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic       done_res;
        logic [3:0] token_pid;
        logic [3:0] token_endpoint;
        logic [6:0] send_length;
        logic       data_toggle;
        logic [6:0] copy_length;
        logic [3:0] final_status;
        logic       final_rx_toggle;
        logic       final_tx_toggle;
    } t_result;

    localparam t_state STATE_RESET = '{
        stage:        ST_IDLE,
        remaining:    16'd0,
        retry_count:  8'd0,
        endpoint:     4'd0,
        packet_limit: 7'd0,
        rx_toggle:    1'b0,
        tx_toggle:    1'b0,
        ctl_dir:      1'b0,
        keep_rx:      1'b0,
        keep_tx:      1'b0
    };

endpackage

// ===== rtl/uhts_step.sv =====
// Next-state and result logic for one transaction of the transfer sequencer.
module uhts_step #(
    parameter int BUFFER_BYTES = uhts_pkg::BUFFER_BYTES_DEF
) (
    input  uhts_pkg::t_state  i_state,
    input  uhts_pkg::t_item   i_item,
    input  logic [7:0]        i_in_nak_limit,
    input  logic [7:0]        i_out_nak_limit,
    output uhts_pkg::t_state  o_state,
    output logic              o_emit,
    output uhts_pkg::t_result o_result
);

    localparam logic [6:0] BUF_LIMIT = 7'(BUFFER_BYTES);

    // Bytes of the next OUT data packet.
    function automatic logic [6:0] f_chunk(input logic [15:0] rem, input logic [6:0] plim);
        logic [6:0] c;
        c = (rem > {9'd0, plim}) ? plim : rem[6:0];
        return c;
    endfunction

    // Token for the stage held in the given state.
    function automatic uhts_pkg::t_result f_issue(input uhts_pkg::t_state st,
                                                  input logic [6:0] copy);
        uhts_pkg::t_result r;
        r = '0;
        r.token_endpoint = st.endpoint;
        r.copy_length    = copy;
        unique case (st.stage)
            uhts_pkg::ST_SETUP: begin
                r.token_pid   = uhts_pkg::PID_SETUP;
                r.send_length = uhts_pkg::SETUP_BYTES;
                r.data_toggle = 1'b0;
            end
            uhts_pkg::ST_CTL_IN, uhts_pkg::ST_STATUS_IN, uhts_pkg::ST_BULK_IN: begin
                r.token_pid   = uhts_pkg::PID_IN;
                r.data_toggle = st.rx_toggle;
            end
            uhts_pkg::ST_STATUS_OUT: begin
                r.token_pid   = uhts_pkg::PID_OUT;
                r.data_toggle = st.tx_toggle;
            end
            default: begin
                r.token_pid   = uhts_pkg::PID_OUT;
                r.data_toggle = st.tx_toggle;
                r.send_length = f_chunk(st.remaining, st.packet_limit);
            end
        endcase
        return r;
    endfunction

    // Completion; a control transfer ending before its status stage reports
    // the toggles it started with.
    function automatic uhts_pkg::t_result f_finish(input uhts_pkg::t_state st,
                                                   input logic [3:0] status,
                                                   input logic [6:0] copy);
        uhts_pkg::t_result r;
        logic early;
        early = (st.stage == uhts_pkg::ST_SETUP) || (st.stage == uhts_pkg::ST_CTL_IN)
             || (st.stage == uhts_pkg::ST_CTL_OUT);
        r = '0;
        r.done_res        = 1'b1;
        r.copy_length     = copy;
        r.final_status    = status;
        r.final_rx_toggle = early ? st.keep_rx : st.rx_toggle;
        r.final_tx_toggle = early ? st.keep_tx : st.tx_toggle;
        return r;
    endfunction

    logic [6:0]  mp_sat;
    logic [6:0]  rx_sat;
    logic        accepted;
    logic [7:0]  limit;
    logic [7:0]  nak_next;
    logic [6:0]  copy;
    logic [15:0] rem_next;
    logic        do_issue;
    logic        do_finish;
    logic [3:0]  status;
    uhts_pkg::t_state ns;

    assign mp_sat   = (i_item.max_packet > BUF_LIMIT) ? BUF_LIMIT : i_item.max_packet;
    assign rx_sat   = (i_item.received_length > BUF_LIMIT) ? BUF_LIMIT
                                                           : i_item.received_length;
    assign accepted = i_item.toggle_ok && (i_item.response_pid != uhts_pkg::PID_NONE)
                   && (i_item.response_pid != uhts_pkg::PID_STALL);
    assign nak_next = 8'(i_state.retry_count + 8'd1);

    // NAK limit of the running stage; control stages retry without limit.
    always_comb begin
        unique case (i_state.stage)
            uhts_pkg::ST_BULK_IN:  limit = i_in_nak_limit;
            uhts_pkg::ST_BULK_OUT: limit = i_out_nak_limit;
            default:               limit = uhts_pkg::NAK_UNLIMITED;
        endcase
    end

    // Bytes taken from a received IN packet and what remains of the transfer.
    always_comb begin
        copy = 7'd0;
        rem_next = i_state.remaining;
        if (i_state.stage == uhts_pkg::ST_CTL_IN || i_state.stage == uhts_pkg::ST_BULK_IN) begin
            copy = ({9'd0, rx_sat} > i_state.remaining) ? i_state.remaining[6:0] : rx_sat;
            rem_next = i_state.remaining - {9'd0, copy};
        end else begin
            rem_next = i_state.remaining
                     - {9'd0, f_chunk(i_state.remaining, i_state.packet_limit)};
        end
    end

    // Transaction decode and state update.
    always_comb begin
        ns        = i_state;
        do_issue  = 1'b0;
        do_finish = 1'b0;
        status    = i_item.response_pid;
        if (i_item.kind != uhts_pkg::KIND_RESULT) begin
            // A start command abandons any running transfer.
            ns.endpoint     = i_item.endpoint;
            ns.packet_limit = mp_sat;
            ns.remaining    = i_item.transfer_length;
            ns.rx_toggle    = i_item.saved_rx_toggle;
            ns.keep_rx      = i_item.saved_rx_toggle;
            ns.tx_toggle    = i_item.saved_tx_toggle;
            ns.keep_tx      = i_item.saved_tx_toggle;
            ns.ctl_dir      = i_item.direction_in;
            ns.retry_count  = 8'd0;
            do_issue        = 1'b1;
            unique case (i_item.kind)
                uhts_pkg::KIND_CONTROL: begin
                    ns.stage = uhts_pkg::ST_SETUP;
                    if (!i_item.has_buffer) begin
                        ns.remaining = 16'd0;
                    end
                end
                uhts_pkg::KIND_IN: ns.stage = uhts_pkg::ST_BULK_IN;
                default:           ns.stage = uhts_pkg::ST_BULK_OUT;
            endcase
        end else if (i_state.stage != uhts_pkg::ST_IDLE) begin
            if (!i_item.completed) begin
                // Timeout.
                do_finish = 1'b1;
                status    = uhts_pkg::PID_NONE;
            end else if (i_item.response_pid == uhts_pkg::PID_NAK) begin
                // Retry, unless the NAK limit is used up.
                if (limit != uhts_pkg::NAK_UNLIMITED) begin
                    ns.retry_count = nak_next;
                end
                if (limit != uhts_pkg::NAK_UNLIMITED && nak_next > limit) begin
                    do_finish = 1'b1;
                end else begin
                    do_issue = 1'b1;
                end
            end else begin
                unique case (i_state.stage)
                    uhts_pkg::ST_SETUP: begin
                        if (i_item.response_pid != uhts_pkg::PID_ACK) begin
                            do_finish = 1'b1;
                        end else begin
                            ns.rx_toggle   = 1'b1;
                            ns.tx_toggle   = 1'b1;
                            ns.retry_count = 8'd0;
                            do_issue       = 1'b1;
                            if (i_state.remaining == 16'd0) begin
                                ns.stage = uhts_pkg::ST_STATUS_IN;
                            end else if (i_state.ctl_dir) begin
                                ns.stage = uhts_pkg::ST_CTL_IN;
                            end else begin
                                ns.stage = uhts_pkg::ST_CTL_OUT;
                            end
                        end
                    end
                    uhts_pkg::ST_CTL_IN, uhts_pkg::ST_BULK_IN: begin
                        if (!accepted) begin
                            do_finish = 1'b1;
                        end else begin
                            ns.rx_toggle = ~i_state.rx_toggle;
                            ns.remaining = rem_next;
                            if (rx_sat == i_state.packet_limit && rem_next != 16'd0) begin
                                ns.retry_count = 8'd0;
                                do_issue       = 1'b1;
                            end else if (i_state.stage == uhts_pkg::ST_BULK_IN) begin
                                do_finish = 1'b1;
                            end else begin
                                ns.stage       = uhts_pkg::ST_STATUS_OUT;
                                ns.retry_count = 8'd0;
                                do_issue       = 1'b1;
                            end
                        end
                    end
                    uhts_pkg::ST_CTL_OUT, uhts_pkg::ST_BULK_OUT: begin
                        if (i_item.response_pid != uhts_pkg::PID_ACK) begin
                            do_finish = 1'b1;
                        end else begin
                            ns.tx_toggle = ~i_state.tx_toggle;
                            ns.remaining = rem_next;
                            if (rem_next != 16'd0) begin
                                ns.retry_count = 8'd0;
                                do_issue       = 1'b1;
                            end else if (i_state.stage == uhts_pkg::ST_BULK_OUT) begin
                                do_finish = 1'b1;
                            end else begin
                                ns.stage       = uhts_pkg::ST_STATUS_IN;
                                ns.retry_count = 8'd0;
                                do_issue       = 1'b1;
                            end
                        end
                    end
                    uhts_pkg::ST_STATUS_IN: begin
                        ns.rx_toggle = i_state.rx_toggle ^ accepted;
                        do_finish    = 1'b1;
                    end
                    default: begin
                        ns.tx_toggle = i_state.tx_toggle
                                     ^ (i_item.response_pid == uhts_pkg::PID_ACK);
                        do_finish    = 1'b1;
                    end
                endcase
            end
        end
    end

    // Result selection; the copy length is only reported for an accepted IN packet.
    logic [6:0] copy_out;

    assign copy_out = (i_item.kind == uhts_pkg::KIND_RESULT && i_item.completed
                       && i_item.response_pid != uhts_pkg::PID_NAK && accepted
                       && (i_state.stage == uhts_pkg::ST_CTL_IN
                           || i_state.stage == uhts_pkg::ST_BULK_IN)) ? copy : 7'd0;

    always_comb begin
        o_state  = ns;
        o_emit   = do_issue | do_finish;
        o_result = '0;
        if (do_finish) begin
            o_result            = f_finish(ns, status, copy_out);
            o_state.stage       = uhts_pkg::ST_IDLE;
            o_state.retry_count = 8'd0;
        end else if (do_issue) begin
            o_result = f_issue(ns, copy_out);
        end
    end

endmodule

// ===== rtl/usb_host_transfer_sequencer.sv =====
// USB host transfer sequencer: input register, transaction logic and result register.
// A transaction is held in the input register; its result is registered in the result
// register once that register is free or being emptied.
// Throughput: one transaction per cycle; the input stalls only while both registers are full.
// Reset (synchronous, active low) returns the transfer to idle, clears all state
// and both NAK limits, and empties the input and result registers.
module usb_host_transfer_sequencer #(
    parameter int BUFFER_BYTES = uhts_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_endpoint,
    input  logic [6:0]  i_max_packet,
    input  logic [15:0] i_transfer_length,
    input  logic        i_direction_in,
    input  logic        i_has_buffer,
    input  logic        i_saved_rx_toggle,
    input  logic        i_saved_tx_toggle,
    input  logic        i_completed,
    input  logic [3:0]  i_response_pid,
    input  logic [6:0]  i_received_length,
    input  logic        i_toggle_ok,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_done_res,
    output logic [3:0]  o_token_pid,
    output logic [3:0]  o_token_endpoint,
    output logic [6:0]  o_send_length,
    output logic        o_data_toggle,
    output logic [6:0]  o_copy_length,
    output logic [3:0]  o_final_status,
    output logic        o_final_rx_toggle,
    output logic        o_final_tx_toggle
);

    logic [7:0]        r_in_nak_limit;
    logic [7:0]        r_out_nak_limit;
    logic              r_in_valid;
    uhts_pkg::t_item   r_item;
    uhts_pkg::t_state  r_state;
    logic              r_out_valid;
    uhts_pkg::t_result r_result;

    uhts_pkg::t_state  n_state;
    uhts_pkg::t_result n_result;
    logic              step_emit;
    logic              in_accept;
    logic              step_fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_nak_limit  <= 8'd0;
            r_out_nak_limit <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uhts_pkg::CFG_IN_NAK_LIMIT:  r_in_nak_limit  <= i_cfg_data;
                uhts_pkg::CFG_OUT_NAK_LIMIT: r_out_nak_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The step stage fires when the result register is free or being emptied.
    assign step_fire = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.kind            <= uhts_pkg::t_kind'(i_kind);
            r_item.endpoint        <= i_endpoint;
            r_item.max_packet      <= i_max_packet;
            r_item.transfer_length <= i_transfer_length;
            r_item.direction_in    <= i_direction_in;
            r_item.has_buffer      <= i_has_buffer;
            r_item.saved_rx_toggle <= i_saved_rx_toggle;
            r_item.saved_tx_toggle <= i_saved_tx_toggle;
            r_item.completed       <= i_completed;
            r_item.response_pid    <= i_response_pid;
            r_item.received_length <= i_received_length;
            r_item.toggle_ok       <= i_toggle_ok;
        end
    end

    // Transaction logic.
    uhts_step #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_step (
        .i_state         (r_state),
        .i_item          (r_item),
        .i_in_nak_limit  (r_in_nak_limit),
        .i_out_nak_limit (r_out_nak_limit),
        .o_state         (n_state),
        .o_emit          (step_emit),
        .o_result        (n_result)
    );

    // Transfer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uhts_pkg::STATE_RESET;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= step_emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && step_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_done_res        = r_result.done_res;
    assign o_token_pid       = r_result.token_pid;
    assign o_token_endpoint  = r_result.token_endpoint;
    assign o_send_length     = r_result.send_length;
    assign o_data_toggle     = r_result.data_toggle;
    assign o_copy_length     = r_result.copy_length;
    assign o_final_status    = r_result.final_status;
    assign o_final_rx_toggle = r_result.final_rx_toggle;
    assign o_final_tx_toggle = r_result.final_tx_toggle;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the USB host transfer sequencer.
module tb_top;
    import uhts_pkg::*;

    localparam int BUF_BYTES       = BUFFER_BYTES_DEF;
    localparam int ITEMS_PER_PHASE = 305;
    localparam int PHASES          = 6;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_AT         = 800;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;

    // Data PIDs returned for IN tokens, and one the block gives no meaning to.
    localparam logic [3:0] PID_DATA0  = 4'h3;
    localparam logic [3:0] PID_DATA1  = 4'hB;
    localparam logic [3:0] PID_UNUSED = 4'h5;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_SILENT} t_row_check;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    typedef struct {
        t_item      it;
        t_row_check chk;
        t_result    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = 2'd0;
    logic [3:0]  i_endpoint = 4'd0;
    logic [6:0]  i_max_packet = 7'd0;
    logic [15:0] i_transfer_length = 16'd0;
    logic        i_direction_in = 1'b0;
    logic        i_has_buffer = 1'b0;
    logic        i_saved_rx_toggle = 1'b0;
    logic        i_saved_tx_toggle = 1'b0;
    logic        i_completed = 1'b0;
    logic [3:0]  i_response_pid = 4'd0;
    logic [6:0]  i_received_length = 7'd0;
    logic        i_toggle_ok = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_done_res;
    logic [3:0]  o_token_pid;
    logic [3:0]  o_token_endpoint;
    logic [6:0]  o_send_length;
    logic        o_data_toggle;
    logic [6:0]  o_copy_length;
    logic [3:0]  o_final_status;
    logic        o_final_rx_toggle;
    logic        o_final_tx_toggle;

    // Transfer state and NAK limits as the block should hold them.
    t_state      seq = STATE_RESET;
    logic [7:0]  nak_limit_in = 8'd0;
    logic [7:0]  nak_limit_out = 8'd0;

    t_result     results_due[$];
    t_row        dir_rows[$];
    int          n_errors = 0;
    int          n_accepted = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    usb_host_transfer_sequencer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_endpoint        (i_endpoint),
        .i_max_packet      (i_max_packet),
        .i_transfer_length (i_transfer_length),
        .i_direction_in    (i_direction_in),
        .i_has_buffer      (i_has_buffer),
        .i_saved_rx_toggle (i_saved_rx_toggle),
        .i_saved_tx_toggle (i_saved_tx_toggle),
        .i_completed       (i_completed),
        .i_response_pid    (i_response_pid),
        .i_received_length (i_received_length),
        .i_toggle_ok       (i_toggle_ok),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_done_res        (o_done_res),
        .o_token_pid       (o_token_pid),
        .o_token_endpoint  (o_token_endpoint),
        .o_send_length     (o_send_length),
        .o_data_toggle     (o_data_toggle),
        .o_copy_length     (o_copy_length),
        .o_final_status    (o_final_status),
        .o_final_rx_toggle (o_final_rx_toggle),
        .o_final_tx_toggle (o_final_tx_toggle)
    );

    always #6 i_clk = ~i_clk;

    // Bytes of the next OUT data packet.
    function automatic logic [6:0] out_chunk();
        return (seq.remaining > seq.packet_limit) ? seq.packet_limit : seq.remaining[6:0];
    endfunction

    // Token for the current stage.
    function automatic t_result token_for(logic [6:0] copy);
        t_result r;
        r = '0;
        case (seq.stage)
            ST_SETUP: begin
                r.token_pid   = PID_SETUP;
                r.send_length = SETUP_BYTES;
            end
            ST_CTL_IN, ST_STATUS_IN, ST_BULK_IN: begin
                r.token_pid   = PID_IN;
                r.data_toggle = seq.rx_toggle;
            end
            default: begin
                r.token_pid   = PID_OUT;
                r.data_toggle = seq.tx_toggle;
                if (seq.stage != ST_STATUS_OUT) r.send_length = out_chunk();
            end
        endcase
        r.token_endpoint = seq.endpoint;
        r.copy_length    = copy;
        return r;
    endfunction

    // Completion; a control transfer ending before its status stage hands back its start toggles.
    function automatic t_result finish_transfer(logic [3:0] status, logic [6:0] copy);
        t_result r;
        logic    early;
        early = seq.stage inside {ST_SETUP, ST_CTL_IN, ST_CTL_OUT};
        r = '0;
        r.done_res        = 1'b1;
        r.copy_length     = copy;
        r.final_status    = status;
        r.final_rx_toggle = early ? seq.keep_rx : seq.rx_toggle;
        r.final_tx_toggle = early ? seq.keep_tx : seq.tx_toggle;
        seq.stage       = ST_IDLE;
        seq.retry_count = 8'd0;
        return r;
    endfunction

    function automatic t_result advance(t_stage next, logic [6:0] copy);
        seq.stage       = next;
        seq.retry_count = 8'd0;
        return token_for(copy);
    endfunction

    // Applies one input transaction to the transfer state; returns 1 when it yields a result.
    function automatic bit sequencer_step(input t_item it, output t_result res);
        logic [6:0] rxlen;
        logic [6:0] copy;
        logic [7:0] limit;
        logic       accepted;
        res = '0;
        if (it.kind != KIND_RESULT) begin
            seq.endpoint     = it.endpoint;
            seq.packet_limit = (it.max_packet > BUF_BYTES) ? 7'(BUF_BYTES) : it.max_packet;
            seq.remaining    = it.transfer_length;
            seq.rx_toggle    = it.saved_rx_toggle;
            seq.keep_rx      = it.saved_rx_toggle;
            seq.tx_toggle    = it.saved_tx_toggle;
            seq.keep_tx      = it.saved_tx_toggle;
            seq.ctl_dir      = it.direction_in;
            if (it.kind == KIND_CONTROL) begin
                if (!it.has_buffer) seq.remaining = 16'd0;
                res = advance(ST_SETUP, 7'd0);
            end else begin
                res = advance((it.kind == KIND_IN) ? ST_BULK_IN : ST_BULK_OUT, 7'd0);
            end
            return 1'b1;
        end
        if (seq.stage == ST_IDLE) return 1'b0;
        if (!it.completed) begin
            res = finish_transfer(PID_NONE, 7'd0);
            return 1'b1;
        end

        // NAK: retry the same token unless the bulk limit is used up.
        if (it.response_pid == PID_NAK) begin
            limit = (seq.stage == ST_BULK_IN)  ? nak_limit_in :
                    (seq.stage == ST_BULK_OUT) ? nak_limit_out : NAK_UNLIMITED;
            if (limit != NAK_UNLIMITED) begin
                seq.retry_count = seq.retry_count + 8'd1;
                if (seq.retry_count > limit) begin
                    res = finish_transfer(PID_NAK, 7'd0);
                    return 1'b1;
                end
            end
            res = token_for(7'd0);
            return 1'b1;
        end

        rxlen    = (it.received_length > BUF_BYTES) ? 7'(BUF_BYTES) : it.received_length;
        accepted = it.toggle_ok && it.response_pid != PID_NONE && it.response_pid != PID_STALL;

        case (seq.stage)
            ST_SETUP: begin
                if (it.response_pid != PID_ACK) begin
                    res = finish_transfer(it.response_pid, 7'd0);
                end else begin
                    seq.rx_toggle = 1'b1;
                    seq.tx_toggle = 1'b1;
                    if (seq.remaining == 16'd0) res = advance(ST_STATUS_IN, 7'd0);
                    else res = advance(seq.ctl_dir ? ST_CTL_IN : ST_CTL_OUT, 7'd0);
                end
            end
            ST_CTL_IN, ST_BULK_IN: begin
                if (!accepted) begin
                    res = finish_transfer(it.response_pid, 7'd0);
                end else begin
                    seq.rx_toggle = ~seq.rx_toggle;
                    copy = (rxlen > seq.remaining) ? seq.remaining[6:0] : rxlen;
                    seq.remaining = seq.remaining - 16'(copy);
                    // A full packet with bytes still to come keeps the data phase going.
                    if (rxlen == seq.packet_limit && seq.remaining != 16'd0)
                        res = advance(seq.stage, copy);
                    else if (seq.stage == ST_BULK_IN)
                        res = finish_transfer(it.response_pid, copy);
                    else
                        res = advance(ST_STATUS_OUT, copy);
                end
            end
            ST_CTL_OUT, ST_BULK_OUT: begin
                if (it.response_pid != PID_ACK) begin
                    res = finish_transfer(it.response_pid, 7'd0);
                end else begin
                    seq.tx_toggle = ~seq.tx_toggle;
                    seq.remaining = seq.remaining - 16'(out_chunk());
                    if (seq.remaining != 16'd0) res = advance(seq.stage, 7'd0);
                    else if (seq.stage == ST_BULK_OUT) res = finish_transfer(it.response_pid, 7'd0);
                    else res = advance(ST_STATUS_IN, 7'd0);
                end
            end
            ST_STATUS_IN: begin
                if (accepted) seq.rx_toggle = ~seq.rx_toggle;
                res = finish_transfer(it.response_pid, 7'd0);
            end
            default: begin
                if (it.response_pid == PID_ACK) seq.tx_toggle = ~seq.tx_toggle;
                res = finish_transfer(it.response_pid, 7'd0);
            end
        endcase
        return 1'b1;
    endfunction

    function automatic t_item mk_start(t_kind k, logic [3:0] ep, logic [6:0] mp,
                                       logic [15:0] len, logic dir, logic buf_present,
                                       logic rx, logic tx);
        t_item it;
        it = '0;
        it.kind            = k;
        it.endpoint        = ep;
        it.max_packet      = mp;
        it.transfer_length = len;
        it.direction_in    = dir;
        it.has_buffer      = buf_present;
        it.saved_rx_toggle = rx;
        it.saved_tx_toggle = tx;
        return it;
    endfunction

    function automatic t_item mk_result(logic done_ok, logic [3:0] pid, logic [6:0] rxlen,
                                        logic tog_ok);
        t_item it;
        it = '0;
        it.kind            = KIND_RESULT;
        it.completed       = done_ok;
        it.response_pid    = pid;
        it.received_length = rxlen;
        it.toggle_ok       = tog_ok;
        return it;
    endfunction

    function automatic t_result token_res(logic [3:0] pid, logic [3:0] ep, logic [6:0] len,
                                          logic tog);
        t_result r;
        r = '0;
        r.token_pid      = pid;
        r.token_endpoint = ep;
        r.send_length    = len;
        r.data_toggle    = tog;
        return r;
    endfunction

    function automatic t_result ended(logic [3:0] status, logic rx, logic tx);
        t_result r;
        r = '0;
        r.done_res        = 1'b1;
        r.final_status    = status;
        r.final_rx_toggle = rx;
        r.final_tx_toggle = tx;
        return r;
    endfunction

    // Random transaction: mostly plausible device answers for the current stage, some noise.
    function automatic t_item random_item();
        t_item                   it;
        logic [$bits(t_item)-1:0] raw;
        int                      roll;
        int                      pick;
        raw  = $bits(t_item)'({$urandom, $urandom});
        it   = t_item'(raw);
        roll = $urandom_range(0, 99);
        if (roll < 8) return it;

        // New transfer when idle, and now and then one that abandons the running transfer.
        if (seq.stage == ST_IDLE || roll < 11) begin
            it.kind = t_kind'($urandom_range(0, 2));
            pick = $urandom_range(0, 19);
            if (pick < 12) it.max_packet = 7'(8 << $urandom_range(0, 3));
            else if (pick < 17) it.max_packet = 7'($urandom_range(0, 64));
            else if (pick < 19) it.max_packet = 7'($urandom_range(65, 127));
            else it.max_packet = 7'd0;
            if ($urandom_range(0, 19) == 0) it.transfer_length = 16'($urandom);
            else it.transfer_length = 16'($urandom_range(0, 300));
            it.has_buffer = ($urandom_range(0, 9) != 0);
            return it;
        end

        it.kind      = KIND_RESULT;
        it.completed = ($urandom_range(0, 49) != 0);
        it.toggle_ok = ($urandom_range(0, 19) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 12) it.response_pid = PID_NAK;
        else if (roll < 15) it.response_pid = PID_STALL;
        else if (roll >= 20) begin
            if (seq.stage inside {ST_CTL_IN, ST_STATUS_IN, ST_BULK_IN})
                it.response_pid = $urandom_range(0, 1) ? PID_DATA1 : PID_DATA0;
            else
                it.response_pid = PID_ACK;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) it.received_length = seq.packet_limit;
        else if (pick < 9) it.received_length = 7'($urandom_range(0, seq.packet_limit));
        return it;
    endfunction

    // Offers one transaction and waits for it to be taken; the predictor runs on acceptance.
    task automatic send_item(input t_item it, output bit made, output t_result res);
        i_kind            <= it.kind;
        i_endpoint        <= it.endpoint;
        i_max_packet      <= it.max_packet;
        i_transfer_length <= it.transfer_length;
        i_direction_in    <= it.direction_in;
        i_has_buffer      <= it.has_buffer;
        i_saved_rx_toggle <= it.saved_rx_toggle;
        i_saved_tx_toggle <= it.saved_tx_toggle;
        i_completed       <= it.completed;
        i_response_pid    <= it.response_pid;
        i_received_length <= it.received_length;
        i_toggle_ok       <= it.toggle_ok;
        i_valid           <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_accepted++;
        made = sequencer_step(it, res);
    endtask

    // Sender bursts: valid stays high within a burst, then, with gaps on, drops for a random gap.
    task automatic pace(input bit gaps_on);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_nak_limits(input logic [7:0] in_lim, input logic [7:0] out_lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IN_NAK_LIMIT;
        i_cfg_data  <= in_lim;
        @(posedge i_clk);
        i_cfg_index <= CFG_OUT_NAK_LIMIT;
        i_cfg_data  <= out_lim;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        nak_limit_in  = in_lim;
        nak_limit_out = out_lim;
    endtask

    task automatic compare_field(input string name, input logic [6:0] want,
                                 input logic [6:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got done=%0b pid=%0h",
                         $time, o_done_res, o_token_pid);
                n_errors++;
            end else begin
                want = results_due.pop_front();
                compare_field("done_res", 7'(want.done_res), 7'(o_done_res));
                compare_field("token_pid", 7'(want.token_pid), 7'(o_token_pid));
                compare_field("token_endpoint", 7'(want.token_endpoint), 7'(o_token_endpoint));
                compare_field("send_length", want.send_length, o_send_length);
                compare_field("data_toggle", 7'(want.data_toggle), 7'(o_data_toggle));
                compare_field("copy_length", want.copy_length, o_copy_length);
                compare_field("final_status", 7'(want.final_status), 7'(o_final_status));
                compare_field("final_rx_toggle", 7'(want.final_rx_toggle),
                              7'(o_final_rx_toggle));
                compare_field("final_tx_toggle", 7'(want.final_tx_toggle),
                              7'(o_final_tx_toggle));
            end
        end
    end

    // Receiver stall pattern, with one long hold-off once traffic is under way.
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        bit       hold_done;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FREE:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                    default:  i_stall <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_result pred;
        bit      made;
        int      n_made;
        bit      gaps_on;

        // Directed transactions; the idle result, a NAK over a zero limit and a timeout
        // have outcomes that can be read off directly.
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_SILENT, '0});
        dir_rows.push_back('{mk_start(KIND_CONTROL, 4'd15, 7'd64, 16'd16, 1'b1, 1'b1, 1'b0,
                             1'b1), ROW_TYPED, token_res(PID_SETUP, 4'd15, SETUP_BYTES, 1'b0)});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_NAK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_DATA1, 7'd64, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_start(KIND_IN, 4'd0, 7'd127, 16'hFFFF, 1'b0, 1'b0, 1'b1,
                             1'b0), ROW_TYPED, token_res(PID_IN, 4'd0, 7'd0, 1'b1)});
        dir_rows.push_back('{mk_result(1'b1, PID_DATA1, 7'd127, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_NAK, 7'd0, 1'b1), ROW_TYPED,
                             ended(PID_NAK, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_start(KIND_OUT, 4'd9, 7'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1),
                             ROW_TYPED, token_res(PID_OUT, 4'd9, 7'd0, 1'b1)});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_start(KIND_CONTROL, 4'd3, 7'd8, 16'd20, 1'b0, 1'b1, 1'b1,
                             1'b1), ROW_TYPED, token_res(PID_SETUP, 4'd3, SETUP_BYTES, 1'b0)});
        dir_rows.push_back('{mk_result(1'b1, PID_STALL, 7'd0, 1'b1), ROW_TYPED,
                             ended(PID_STALL, 1'b1, 1'b1)});
        dir_rows.push_back('{mk_start(KIND_CONTROL, 4'd4, 7'd8, 16'd100, 1'b1, 1'b0, 1'b0,
                             1'b0), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_DATA1, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_start(KIND_OUT, 4'd2, 7'd64, 16'd130, 1'b0, 1'b0, 1'b0, 1'b0),
                             ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b0, PID_ACK, 7'd0, 1'b1), ROW_TYPED,
                             ended(PID_NONE, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_start(KIND_IN, 4'd1, 7'd8, 16'd20, 1'b0, 1'b0, 1'b0, 1'b0),
                             ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_DATA0, 7'd5, 1'b0), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_start(KIND_CONTROL, 4'd6, 7'd16, 16'd40, 1'b0, 1'b1, 1'b0,
                             1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_ACK, 7'd0, 1'b1), ROW_PREDICT, '0});
        dir_rows.push_back('{mk_start(KIND_IN, 4'd7, 7'd32, 16'd10, 1'b1, 1'b1, 1'b1, 1'b0),
                             ROW_PREDICT, '0});
        dir_rows.push_back('{mk_result(1'b1, PID_UNUSED, 7'd3, 1'b1), ROW_PREDICT, '0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with the NAK limits as they come out of reset.
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].it, made, pred);
            if (dir_rows[k].chk == ROW_TYPED) results_due.push_back(dir_rows[k].want);
            else if (dir_rows[k].chk == ROW_PREDICT && made) results_due.push_back(pred);
            pace(1'b1);
        end
        i_valid <= 1'b0;

        // Random phases, each under its own pair of NAK limits, written once traffic has drained.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: set_nak_limits(NAK_UNLIMITED, NAK_UNLIMITED);
                1: set_nak_limits(8'd0, 8'd0);
                2: set_nak_limits(8'd1, 8'd3);
                3: set_nak_limits(8'd254, 8'd2);
                default: set_nak_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            gaps_on = (phase != 1);
            n_made  = 0;
            while (n_made < ITEMS_PER_PHASE) begin
                send_item(random_item(), made, pred);
                if (made) begin
                    results_due.push_back(pred);
                    n_made++;
                end
                pace(gaps_on);
            end
            i_valid <= 1'b0;
        end

        drain();
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
